FILE: sv/fpmt_pkg.sv
`default_nettype none
package fpmt_pkg;

    localparam int INDEX_BITS = 16;
    localparam int POS_W      = 16;
    localparam int VAL_W      = 51;
    localparam int DEPTH      = 1 << INDEX_BITS;
    // walk index: wide enough for any position and for one step past the top node
    localparam int CNT_W      = ((INDEX_BITS > POS_W) ? INDEX_BITS : POS_W) + 1;
    localparam logic [CNT_W-1:0] TOP_POS = CNT_W'(DEPTH - 1);

    localparam logic signed [VAL_W-1:0] EMPTY_MARK = VAL_W'(-64'sd1000000000000000);

    typedef enum logic [1:0] {
        OP_RAISE = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] prefix_max;
        logic                    was_query;
    } result_t;

endpackage
`default_nettype wire

FILE: sv/fpmt_req_if.sv
`default_nettype none
interface fpmt_req_if;
    import fpmt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output operation, output position, output new_value,
                    input ready);
    modport sink (input valid, input operation, input position, input new_value,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/fpmt_rsp_if.sv
`default_nettype none
interface fpmt_rsp_if;
    import fpmt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] prefix_max;
    logic                    was_query;

    modport source (output valid, output prefix_max, output was_query, input ready);
    modport sink (input valid, input prefix_max, input was_query, output ready);
endinterface
`default_nettype wire

FILE: sv/fenwick_prefix_max_tree.sv
`default_nettype none
// Channel  Direction  Payload
// req      in         operation[1:0], position[15:0], new_value[50:0] signed
// rsp      out        prefix_max[50:0] signed, was_query
//
// An item is walked one node memory read-modify-write per cycle, and its result
// then goes to the output register.
// The next item is taken only after the previous result has left the walker.
// After reset the node memory is swept to the empty marker, with req.ready low.
// The output register takes a result while rsp is stalled; a further item
// finishes its walk and then waits until that register is emptied.
module fenwick_prefix_max_tree (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fpmt_req_if.sink   req,
    fpmt_rsp_if.source rsp
);
    import fpmt_pkg::*;

    logic                    done_valid, done_ready;
    result_t                 done_res;
    logic                    ram_we, ram_re;
    logic [INDEX_BITS-1:0]   ram_waddr, ram_raddr;
    logic signed [VAL_W-1:0] ram_wdata, ram_rdata;

    logic    out_valid_reg;
    result_t out_res_reg;

    fpmt_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .op         (req.operation),
        .pos        (req.position),
        .val        (req.new_value),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_res   (done_res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    fpmt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done_ready     = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.prefix_max = out_res_reg.prefix_max;
    assign rsp.was_query  = out_res_reg.was_query;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
        begin
            out_res_reg <= done_res;
        end
    end
endmodule
`default_nettype wire

FILE: sv/fpmt_ram.sv
`default_nettype none
module fpmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output      logic [WIDTH-1:0]           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/fpmt_walker.sv
`default_nettype none
module fpmt_walker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output      logic                                   req_ready,
    input  wire logic [1:0]                             op,
    input  wire logic [fpmt_pkg::POS_W-1:0]             pos,
    input  wire logic signed [fpmt_pkg::VAL_W-1:0]      val,
    output      logic                                   done_valid,
    input  wire logic                                   done_ready,
    output      fpmt_pkg::result_t                      done_res,
    output      logic                                   ram_we,
    output      logic [fpmt_pkg::INDEX_BITS-1:0]        ram_waddr,
    output      logic signed [fpmt_pkg::VAL_W-1:0]      ram_wdata,
    output      logic                                   ram_re,
    output      logic [fpmt_pkg::INDEX_BITS-1:0]        ram_raddr,
    input  wire logic signed [fpmt_pkg::VAL_W-1:0]      ram_rdata
);
    import fpmt_pkg::*;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]        rd_pos_reg, rd_pos_next;
    logic                    pend_reg, pend_next;
    logic [INDEX_BITS-1:0]   pend_addr_reg, pend_addr_next;
    logic [INDEX_BITS-1:0]   sweep_reg, sweep_next;

    logic             is_query, is_up;
    logic             rd_ok;
    logic [CNT_W-1:0] low_bit, pos_ext;
    logic             accept;

    assign is_query = (op_reg == OP_QUERY);
    assign is_up    = (op_reg == OP_RAISE) || (op_reg == OP_CLEAR);
    assign low_bit  = rd_pos_reg & (~rd_pos_reg + CNT_W'(1));
    assign rd_ok    = (rd_pos_reg != '0) &&
                      (is_query || (is_up && (rd_pos_reg[CNT_W-1:INDEX_BITS] == '0)));
    assign pos_ext  = CNT_W'(pos);
    assign accept   = req_valid && req_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!rd_ok && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        op_next        = op_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        rd_pos_next    = rd_pos_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        sweep_next     = sweep_reg;
        if (state_reg == ST_SWEEP)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
        if (accept)
        begin
            op_next   = op;
            val_next  = val;
            best_next = EMPTY_MARK;
            // a query past the top node covers the whole tree
            if ((op == OP_QUERY) && (pos_ext > TOP_POS))
            begin
                rd_pos_next = TOP_POS;
            end
            else
            begin
                rd_pos_next = pos_ext;
            end
        end
        else if (state_reg == ST_WALK)
        begin
            if (pend_reg && is_query && (ram_rdata > best_reg))
            begin
                best_next = ram_rdata;
            end
            if (rd_ok)
            begin
                pend_next      = 1'b1;
                pend_addr_next = rd_pos_reg[INDEX_BITS-1:0];
                rd_pos_next    = is_query ? (rd_pos_reg - low_bit) : (rd_pos_reg + low_bit);
            end
        end
    end

    // outputs
    always_comb
    begin
        req_ready           = (state_reg == ST_IDLE);
        done_valid          = (state_reg == ST_FINISH);
        done_res.prefix_max = is_query ? best_reg : '0;
        done_res.was_query  = is_query;
        ram_re              = (state_reg == ST_WALK) && rd_ok;
        ram_raddr           = rd_pos_reg[INDEX_BITS-1:0];
        ram_we              = 1'b0;
        ram_waddr           = pend_addr_reg;
        ram_wdata           = (op_reg == OP_RAISE) ? val_reg : EMPTY_MARK;
        if (state_reg == ST_SWEEP)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = EMPTY_MARK;
        end
        else if ((state_reg == ST_WALK) && pend_reg)
        begin
            // the read ahead is always a different node than the one written back
            ram_we = (op_reg == OP_CLEAR) ||
                     ((op_reg == OP_RAISE) && (ram_rdata < val_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
            op_reg    <= OP_RAISE;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        best_reg      <= best_next;
        rd_pos_reg    <= rd_pos_next;
        pend_addr_reg <= pend_addr_next;
    end
endmodule
`default_nettype wire

FILE: tb/tb_fenwick_prefix_max_tree.sv
`timescale 1ns / 100ps
module tb_fenwick_prefix_max_tree;
    import fpmt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned HOLD_CYCLES  = 500;

    typedef struct {
        logic [1:0]              op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        bit                      drain;
    } req_item_t;

    logic clk;
    logic rst_n;

    fpmt_req_if req_ch ();
    fpmt_rsp_if rsp_ch ();

    fenwick_prefix_max_tree dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // shadow copy of the node store and the answers still owed by the block
    logic signed [VAL_W-1:0] node_max [0:DEPTH-1];
    req_item_t               op_queue [$];
    result_t                 answer_q [$];

    int unsigned n_raise, n_query, n_clear, n_ignored, n_hit;
    int unsigned n_results, n_errors, cycle_count;
    int unsigned gap_left, burst_left;
    int unsigned stall_cycle, stall_mode, hold_left;
    bit          hold_done;
    req_item_t   issued;
    result_t     want;

    function automatic logic signed [VAL_W-1:0] any_value();
        return VAL_W'({$urandom, $urandom});
    endfunction

    task automatic add_item(input logic [1:0] op, input int unsigned pos,
                            input logic signed [VAL_W-1:0] val, input bit drain);
        req_item_t it;
        it.op    = op;
        it.pos   = pos[POS_W-1:0];
        it.val   = val;
        it.drain = drain;
        op_queue.push_back(it);
    endtask

    // apply one item to the shadow tree and queue the answer it owes
    function automatic void tree_apply(input req_item_t it);
        int unsigned             p;
        logic signed [VAL_W-1:0] best;
        result_t                 ans;
        ans.prefix_max = '0;
        ans.was_query  = 1'b0;
        p = 32'(it.pos);
        case (it.op)
            OP_RAISE:
            begin
                n_raise++;
                while (p != 0 && p <= TOP_POS)
                begin
                    if (node_max[p[INDEX_BITS-1:0]] < it.val)
                        node_max[p[INDEX_BITS-1:0]] = it.val;
                    p += p & (~p + 1);
                end
            end
            OP_CLEAR:
            begin
                n_clear++;
                while (p != 0 && p <= TOP_POS)
                begin
                    node_max[p[INDEX_BITS-1:0]] = EMPTY_MARK;
                    p += p & (~p + 1);
                end
            end
            OP_QUERY:
            begin
                n_query++;
                best = EMPTY_MARK;
                if (p > TOP_POS)
                    p = 32'(TOP_POS);
                while (p != 0)
                begin
                    if (node_max[p[INDEX_BITS-1:0]] > best)
                        best = node_max[p[INDEX_BITS-1:0]];
                    p -= p & (~p + 1);
                end
                ans.prefix_max = best;
                ans.was_query  = 1'b1;
                if (best != EMPTY_MARK)
                    n_hit++;
            end
            default:
                n_ignored++;
        endcase
        answer_q.push_back(ans);
    endfunction

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d items pending, %0d answers owed",
                   cycle_count, op_queue.size(), answer_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // sender: bursts of items with random gaps; valid is held until the item is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_RAISE;
            req_ch.position  <= '0;
            req_ch.new_value <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                tree_apply(op_queue.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                              : $urandom_range(1, 30);
                end
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // item still on offer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (op_queue.size() == 0 || (op_queue[0].drain && answer_q.size() != 0))
                req_ch.valid <= 1'b0;
            else
            begin
                issued = op_queue[0];
                req_ch.valid     <= 1'b1;
                req_ch.operation <= issued.op;
                req_ch.position  <= issued.pos;
                req_ch.new_value <= issued.val;
            end
        end
    end

    // receiver: switches among random stall patterns, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                if (answer_q.size() == 0)
                begin
                    $error("result with nothing owed: prefix_max %0d, was_query %0b",
                           rsp_ch.prefix_max, rsp_ch.was_query);
                    n_errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp_ch.prefix_max !== want.prefix_max)
                    begin
                        $error("prefix_max: expected %0d, actual %0d",
                               want.prefix_max, rsp_ch.prefix_max);
                        n_errors++;
                    end
                    if (rsp_ch.was_query !== want.was_query)
                    begin
                        $error("was_query: expected %0b, actual %0b",
                               want.was_query, rsp_ch.was_query);
                        n_errors++;
                    end
                end
            end
            stall_cycle++;
            if (stall_cycle % 48 == 0)
                stall_mode = $urandom_range(0, 4);
            if (!hold_done && n_results >= 400)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
                    3: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= stall_cycle[2];
                endcase
        end
    end

    initial
    begin
        int unsigned             n_items, phase_no, phase_len, span_bits, k, pick;
        int unsigned             pos;
        bit                      narrow;
        logic [1:0]              op;
        logic signed [VAL_W-1:0] val;

        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_RAISE;
        req_ch.position  = '0;
        req_ch.new_value = '0;
        rsp_ch.ready     = 1'b0;
        stall_mode       = 0;
        burst_left       = 8;
        foreach (node_max[i])
            node_max[i] = EMPTY_MARK;

        // directed: empty prefix, end positions, value extremes, ignored code
        add_item(OP_QUERY, 0, any_value(), 1'b0);
        add_item(OP_QUERY, 65535, any_value(), 1'b0);
        add_item(OP_RAISE, 0, VAL_MAX, 1'b0);
        add_item(OP_QUERY, 65535, any_value(), 1'b0);
        add_item(OP_RAISE, 1, VAL_MIN, 1'b0);
        add_item(OP_QUERY, 1, any_value(), 1'b0);
        add_item(OP_RAISE, 65535, VAL_MAX, 1'b0);
        add_item(OP_QUERY, 65534, any_value(), 1'b0);
        add_item(OP_QUERY, 65535, any_value(), 1'b0);
        add_item(OP_RAISE, 32768, VAL_W'(5), 1'b0);
        add_item(OP_QUERY, 40000, any_value(), 1'b0);
        add_item(OP_CLEAR, 0, any_value(), 1'b0);
        add_item(OP_CLEAR, 65535, any_value(), 1'b0);
        add_item(OP_QUERY, 65535, any_value(), 1'b0);
        add_item(OP_CLEAR, 32768, any_value(), 1'b0);
        add_item(OP_QUERY, 65535, any_value(), 1'b0);
        add_item(OP_RAISE, 1, VAL_W'(-1), 1'b0);
        add_item(OP_RAISE, 3, EMPTY_MARK, 1'b0);
        add_item(OP_QUERY, 3, any_value(), 1'b0);
        add_item(OP_UNUSED, 1, VAL_MAX, 1'b0);
        add_item(OP_QUERY, 2, any_value(), 1'b0);
        add_item(OP_CLEAR, 1, any_value(), 1'b0);
        add_item(OP_QUERY, 65535, any_value(), 1'b0);
        add_item(OP_UNUSED, 65535, any_value(), 1'b0);
        add_item(OP_RAISE, 2, VAL_MIN, 1'b0);

        // random phases: mostly small windows so raises, clears and queries collide
        n_items  = 0;
        phase_no = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(30, 120);
            narrow    = ($urandom_range(0, 9) < 6);
            span_bits = $urandom_range(2, 9);
            for (k = 0; k < phase_len && n_items < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                op   = (pick < 45) ? OP_RAISE : (pick < 90) ? OP_QUERY : OP_CLEAR;
                if (narrow)
                    pos = $urandom_range(0, 1 << span_bits);
                else if ($urandom_range(0, 9) == 0)
                    pos = 65535 - $urandom_range(0, 16);
                else
                    pos = $urandom_range(0, 65535);
                case ($urandom_range(0, 9))
                    0: val = EMPTY_MARK + VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
                    1: val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                    2, 3, 4, 5: val = VAL_W'($urandom_range(0, 2000)) - VAL_W'(1000);
                    default: val = any_value();
                endcase
                add_item(op, pos, val, (k == 0 && phase_no % 8 == 0));
                n_items++;
            end
            phase_no++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (op_queue.size() != 0 || answer_q.size() != 0);
        repeat (INDEX_BITS + 8) @(posedge clk);

        $display("Covered %0d raises, %0d clears, %0d queries (%0d above the empty marker),",
                 n_raise, n_clear, n_query, n_hit);
        $display("%0d ignored codes; %0d results checked, %0d mismatches",
                 n_ignored, n_results, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/fpmt_pkg.sv
sv/fpmt_req_if.sv
sv/fpmt_rsp_if.sv
sv/fpmt_ram.sv
sv/fpmt_walker.sv
sv/fenwick_prefix_max_tree.sv
tb/tb_fenwick_prefix_max_tree.sv
